@@ hw/rtl/trct_pkg.sv @@
// Shared types, constants and waveform table for the tristate code transmitter.
package trct_pkg;

  localparam int unsigned CODE_W   = 20;
  localparam int unsigned RPT_W    = 4;
  localparam int unsigned PER_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [CODE_W-1:0] CODE_MAX     = {CODE_W{1'b1}};
  localparam logic [RPT_W-1:0]  REPEAT_RESET = RPT_W'(10);
  localparam logic [PER_W-1:0]  DIGIT_LAST   = PER_W'(7);
  localparam logic [PER_W-1:0]  SYNC_LAST    = PER_W'(31);

  // register index, taken from paddr[2]
  localparam logic REG_REPEAT = 1'b0;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CODE_W-1:0] code;
  } q_item_t;

  typedef struct packed {
    logic tx_level;
    logic busy;
    logic rejected;
    logic done;
  } res_t;

  // bit p is the line level in period p of a digit; code 3 stays low
  function automatic logic [7:0] digit_wave(logic [1:0] d);
    logic [7:0] w;
    case (d)
      2'd0:    w = 8'h11;
      2'd1:    w = 8'h77;
      2'd2:    w = 8'h71;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/trct_front.sv @@
// Front end: accepts items, classifies the operation, queues them for the back end.
module trct_front
  import trct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [CODE_W-1:0] code_i,
  output logic              ent_valid_o,
  output q_item_t           ent_o,
  input  logic              ent_pop_i
);

  q_item_t     mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  q_item_t     item;

  always_comb begin
    item.op   = operation_i ? OP_LOAD : OP_TICK;
    item.code = code_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign ent_valid_o = (cnt_q != 2'd0);
  assign ent_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = ent_pop_i && ent_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

@@ hw/rtl/trct_back.sv @@
// Back end: code reduction, telegram sequencer and output register.
module trct_back
  import trct_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RPT_W-1:0] repeat_count_i,
  input  logic             ent_valid_i,
  input  q_item_t          ent_i,
  output logic             ent_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             res_o
);

  function automatic longint pow3_f(int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

  // number of shifted-modulus subtract steps that can matter for a code
  function automatic int red_steps_f(longint m);
    int s;
    s = 0;
    for (int i = 0; i < 64; i++) begin
      if ((m << s) <= longint'(CODE_MAX)) begin
        s = s + 1;
      end
    end
    return s;
  endfunction

  localparam longint      MOD3      = pow3_f(NUM_DIGITS);
  localparam int unsigned MW        = $clog2(MOD3);
  localparam int unsigned RW        = (MW > CODE_W) ? MW : CODE_W;
  localparam int unsigned RED_STEPS = red_steps_f(MOD3);
  localparam int unsigned CW        = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
  localparam int unsigned IW        = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [RW-1:0] MODV    = RW'(MOD3);
  localparam logic [IW-1:0] IDX_LAST = IW'(NUM_DIGITS - 1);

  // weight of digit position i, most significant first
  logic [RW-1:0] pow3_w [NUM_DIGITS];
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_pow3
    assign pow3_w[i] = RW'(pow3_f(NUM_DIGITS - 1 - i));
  end

  logic             active_q, active_d;
  logic             in_sync_q, in_sync_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [PER_W-1:0] per_q, per_d;
  logic [RPT_W-1:0] rep_q, rep_d;
  logic [RW-1:0]    code_q, code_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    red_q, red_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic          red_busy;
  logic          take;
  logic [RW-1:0] p_cur, p_two, p_sub, red_sub;
  logic [1:0]    dig;
  logic [7:0]    wave;

  assign red_busy  = (red_q != '0);
  assign take      = ent_valid_i && !red_busy && (!out_valid_q || out_ready_i);
  assign ent_pop_o = take;

  // current digit from the running remainder
  always_comb begin
    p_cur = pow3_w[idx_q];
    p_two = p_cur << 1;
    if (rem_q >= p_two) begin
      dig   = 2'd2;
      p_sub = p_two;
    end else if (rem_q >= p_cur) begin
      dig   = 2'd1;
      p_sub = p_cur;
    end else begin
      dig   = 2'd0;
      p_sub = '0;
    end
    wave = digit_wave(dig);
  end

  assign red_sub = MODV << (red_q - CW'(1));

  always_comb begin
    active_d    = active_q;
    in_sync_d   = in_sync_q;
    idx_d       = idx_q;
    per_d       = per_q;
    rep_d       = rep_q;
    code_d      = code_q;
    rem_d       = rem_q;
    red_d       = red_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // restoring reduction: code mod 3^NUM_DIGITS, one shifted modulus a step
    if (red_busy) begin
      if (code_q >= red_sub) begin
        code_d = code_q - red_sub;
      end
      rem_d = code_d;
      red_d = red_q - CW'(1);
    end

    if (take) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      if (ent_i.op == OP_LOAD) begin
        res_d.busy = 1'b1;
        if (active_q) begin
          res_d.rejected = 1'b1;
        end else begin
          code_d    = RW'(ent_i.code);
          rem_d     = RW'(ent_i.code);
          red_d     = CW'(RED_STEPS);
          idx_d     = '0;
          per_d     = '0;
          in_sync_d = 1'b0;
          rep_d     = (repeat_count_i == '0) ? RPT_W'(1) : repeat_count_i;
          active_d  = 1'b1;
        end
      end else if (active_q) begin
        res_d.busy = 1'b1;
        if (in_sync_q) begin
          res_d.tx_level = (per_q == '0);
          if (per_q == SYNC_LAST) begin
            per_d     = '0;
            in_sync_d = 1'b0;
            rem_d     = code_q;
            if (rep_q <= RPT_W'(1)) begin
              rep_d      = '0;
              active_d   = 1'b0;
              res_d.done = 1'b1;
            end else begin
              rep_d = rep_q - RPT_W'(1);
            end
          end else begin
            per_d = per_q + PER_W'(1);
          end
        end else begin
          res_d.tx_level = wave[per_q[2:0]];
          if (per_q == DIGIT_LAST) begin
            per_d = '0;
            rem_d = rem_q - p_sub;
            if (idx_q == IDX_LAST) begin
              idx_d     = '0;
              in_sync_d = 1'b1;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end else begin
            per_d = per_q + PER_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      in_sync_q   <= 1'b0;
      idx_q       <= '0;
      per_q       <= '0;
      rep_q       <= '0;
      red_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      in_sync_q   <= in_sync_d;
      idx_q       <= idx_d;
      per_q       <= per_d;
      rep_q       <= rep_d;
      red_q       <= red_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

@@ hw/rtl/tristate_rf_code_transmitter_top.sv @@
// Top level of the tristate RF code transmitter: config register, front end, back end.
// Results: each result is registered as its item leaves the queue.
// Throughput: one item per cycle while the output is not stalled; after an accepted load
//   the back end takes no item while it reduces the code mod 3^NUM_DIGITS; the
//   two-entry queue fills and then holds the input off until the reduction is done.
// Reset: rst_ni is asynchronous, active low; the block comes up idle, queue and
//   output empty, repeat_count at 10. No clearing pass is needed.
module tristate_rf_code_transmitter_top
  import trct_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // item input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [CODE_W-1:0] code_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              tx_level_o,
  output logic              busy_res_o,
  output logic              rejected_o,
  output logic              done_res_o
);

  logic [RPT_W-1:0] repeat_q;
  logic             cfg_wr;
  logic             ent_valid;
  logic             ent_pop;
  q_item_t          ent;
  res_t             res;

  // Single register at byte address 0; writes to the other word are dropped.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REPEAT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q <= REPEAT_RESET;
    end else if (cfg_wr) begin
      repeat_q <= pwdata[RPT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_REPEAT) begin
      prdata = DATA_W'(repeat_q);
    end
  end

  // Front end: accept and classify, buffer up to two items.
  trct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .code_i      (code_i),
    .ent_valid_o (ent_valid),
    .ent_o       (ent),
    .ent_pop_i   (ent_pop)
  );

  // Back end: digit generation, telegram timing, registered result.
  trct_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .repeat_count_i (repeat_q),
    .ent_valid_i    (ent_valid),
    .ent_i          (ent),
    .ent_pop_o      (ent_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .res_o          (res)
  );

  assign tx_level_o = res.tx_level;
  assign busy_res_o = res.busy;
  assign rejected_o = res.rejected;
  assign done_res_o = res.done;

endmodule

@@ sim/trct_telegram_scoreboard.sv @@
// Scoreboard for the tristate code transmitter: predicts each item's result (line level and flags) and checks it.
module trct_telegram_scoreboard
  import trct_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              operation_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              tx_level_i,
  input  logic              busy_res_i,
  input  logic              rejected_i,
  input  logic              done_res_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       loads_o,
  output int unsigned       refused_o,
  output int unsigned       finished_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // transmitter state as predicted
  logic [1:0]       digits [NUM_DIGITS];
  logic [3:0]       digit_pos;
  logic [PER_W-1:0] tick_in_slot;
  logic [RPT_W-1:0] repeats_left;
  logic [RPT_W-1:0] repeat_cfg;
  logic             in_sync;
  logic             tx_active;

  res_t expected_levels [$];

  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned load_cnt     = 0;
  int unsigned refused_cnt  = 0;
  int unsigned finished_cnt = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = expected_levels.size();
  assign checked_o    = checked_cnt;
  assign loads_o      = load_cnt;
  assign refused_o    = refused_cnt;
  assign finished_o   = finished_cnt;

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t ns: %s", $realtime, what);
  endtask

  // one item in, one result out; updates the predicted state
  function automatic res_t advance_transmitter(op_e op, logic [CODE_W-1:0] code);
    res_t        r;
    logic [2:0]  p;
    int unsigned value;
    int          i;
    r = '0;
    if (op == OP_LOAD) begin
      r.busy = 1'b1;
      if (tx_active) begin
        r.rejected = 1'b1;
        refused_cnt++;
      end else begin
        value = code;
        for (i = NUM_DIGITS - 1; i >= 0; i--) begin
          digits[i] = 2'(value % 3);
          value     = value / 3;
        end
        digit_pos    = '0;
        tick_in_slot = '0;
        in_sync      = 1'b0;
        repeats_left = (repeat_cfg == '0) ? RPT_W'(1) : repeat_cfg;
        tx_active    = 1'b1;
        load_cnt++;
      end
    end else if (tx_active) begin
      r.busy = 1'b1;
      if (in_sync) begin
        r.tx_level = (tick_in_slot == '0);
        if (tick_in_slot >= SYNC_LAST) begin
          tick_in_slot = '0;
          in_sync      = 1'b0;
          if (repeats_left <= RPT_W'(1)) begin
            repeats_left = '0;
            tx_active    = 1'b0;
            r.done       = 1'b1;
            finished_cnt++;
          end else begin
            repeats_left--;
          end
        end else begin
          tick_in_slot++;
        end
      end else begin
        p = tick_in_slot[2:0];
        case (digits[digit_pos])
          2'd0:    r.tx_level = (p == 3'd0) || (p == 3'd4);
          2'd1:    r.tx_level = (p != 3'd3) && (p != 3'd7);
          2'd2:    r.tx_level = (p == 3'd0) || (p >= 3'd4 && p <= 3'd6);
          default: r.tx_level = 1'b0;
        endcase
        if (tick_in_slot >= DIGIT_LAST) begin
          tick_in_slot = '0;
          if (int'(digit_pos) + 1 >= NUM_DIGITS) begin
            digit_pos = '0;
            in_sync   = 1'b1;
          end else begin
            digit_pos++;
          end
        end else begin
          tick_in_slot++;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      foreach (digits[k]) digits[k] = '0;
      digit_pos    = '0;
      tick_in_slot = '0;
      repeats_left = '0;
      repeat_cfg   = REPEAT_RESET;
      in_sync      = 1'b0;
      tx_active    = 1'b0;
      expected_levels.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_REPEAT) begin
        if (pwrite) begin
          repeat_cfg = pwdata[RPT_W-1:0];
        end else if (prdata[RPT_W-1:0] !== repeat_cfg) begin
          flag_mismatch($sformatf("repeat_count readback: expected %0d, got %0d",
                                  repeat_cfg, prdata[RPT_W-1:0]));
        end
      end

      if (out_valid_i && out_ready_i) begin
        checked_cnt++;
        got.tx_level = tx_level_i;
        got.busy     = busy_res_i;
        got.rejected = rejected_i;
        got.done     = done_res_i;
        if (expected_levels.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: tx=%b busy=%b rej=%b done=%b",
                                  got.tx_level, got.busy, got.rejected, got.done));
        end else begin
          want = expected_levels.pop_front();
          if (got.tx_level !== want.tx_level || got.busy !== want.busy ||
              got.rejected !== want.rejected || got.done !== want.done) begin
            flag_mismatch($sformatf(
              "result %0d: expected tx=%b busy=%b rej=%b done=%b, got tx=%b busy=%b rej=%b done=%b",
              checked_cnt, want.tx_level, want.busy, want.rejected, want.done,
              got.tx_level, got.busy, got.rejected, got.done));
          end
        end
      end

      if (in_valid_i && in_ready_i)
        expected_levels.push_back(advance_transmitter(op_e'(operation_i), code_i));
    end
  end

endmodule

@@ sim/tb_tristate_rf_code_transmitter_top.sv @@
// Testbench top for the tristate code transmitter: stimulus, idle/stall mixes and verdict.
module tb_tristate_rf_code_transmitter_top
  import trct_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_DIGITS     = 12;
  localparam int unsigned CODE_SPAN      = 3 ** NUM_DIGITS;       // first code that wraps
  localparam int unsigned TELEGRAM_TICKS = NUM_DIGITS * 8 + 32;   // digits plus sync
  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam logic        REG_SPARE      = 1'b1;                  // unmapped register slot

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;
  logic              in_valid_i, in_ready_o;
  logic              operation_i;
  logic [CODE_W-1:0] code_i;
  logic              out_valid_o, out_ready_i;
  logic              tx_level_o, busy_res_o, rejected_o, done_res_o;

  int unsigned mismatches, pending, checked, loads, refused, finished;

  // stimulus shaping
  int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds off
  int unsigned stall_pct     = 0;   // chance per cycle that the receiver stalls
  int unsigned eff_repeats   = 1;   // repeat count as the block will apply it
  int unsigned ticks_left    = 0;   // ticks until the current telegram run ends
  int unsigned items_sent    = 0;
  int unsigned cycle_cnt     = 0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tristate_rf_code_transmitter_top #(
    .NUM_DIGITS (NUM_DIGITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .code_i      (code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_level_o  (tx_level_o),
    .busy_res_o  (busy_res_o),
    .rejected_o  (rejected_o),
    .done_res_o  (done_res_o)
  );

  trct_telegram_scoreboard #(
    .NUM_DIGITS (NUM_DIGITS)
  ) scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .operation_i  (operation_i),
    .code_i       (code_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_level_i   (tx_level_o),
    .busy_res_i   (busy_res_o),
    .rejected_i   (rejected_o),
    .done_res_i   (done_res_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .loads_o      (loads),
    .refused_o    (refused),
    .finished_o   (finished)
  );

  // Receiver: ready redrawn every falling edge, stall rate set per phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a stuck handshake or a lost result ends up here.
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
    $display("Mismatches found");
    $finish;
  end

  // All tasks below are entered and left at a falling edge, so each drive
  // lands at a falling edge, ahead of the rising sampling edge.

  // One APB transfer: setup, access, then idle before the task returns.
  task automatic apb_access(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // New repeat count: upper data bits carry noise, the spare slot gets a
  // write that must not land anywhere, and the value is read back.
  task automatic set_repeats(logic [RPT_W-1:0] rpt);
    apb_access(1'b1, {REG_REPEAT, 2'b00}, {(DATA_W-RPT_W)'($urandom), rpt});
    apb_access(1'b1, {REG_SPARE, 2'b00}, DATA_W'($urandom));
    apb_access(1'b0, {REG_REPEAT, 2'b00}, '0);
    eff_repeats = (rpt == '0) ? 1 : rpt;
  endtask

  // Present one item, keep it until taken; valid stays high on return so a
  // following item goes out back to back.
  task automatic send_item(op_e op, logic [CODE_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    code_i      <= code;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    // track the telegram so the random part knows when a load will be taken
    if (op == OP_LOAD) begin
      if (ticks_left == 0) ticks_left = TELEGRAM_TICKS * eff_repeats;
    end else if (ticks_left != 0) begin
      ticks_left--;
    end
    items_sent++;
  endtask

  // Drop valid and wait until every result is back, then wait on for
  // the back end still reducing the last code.
  task automatic hold_off();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // In four draws of ten a range edge or wrap point, otherwise any 20-bit value.
  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CODE_W'(CODE_SPAN - 1);
      2:       return CODE_W'(CODE_SPAN);
      3:       return CODE_MAX;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  // Random traffic: when idle, mostly start a telegram; while sending, mostly
  // ticks with a sprinkle of loads that must be refused. With drain set the
  // phase runs on until the current telegram run has finished.
  task automatic run_phase(int unsigned budget, bit drain, int unsigned pause_at);
    int unsigned n;
    n = 0;
    while (n < budget || (drain && ticks_left != 0)) begin
      if (pause_at != 0 && n == pause_at) hold_off();
      if (ticks_left == 0 && $urandom_range(99) < 80)
        send_item(OP_LOAD, pick_code());
      else if (ticks_left != 0 && $urandom_range(99) < 4)
        send_item(OP_LOAD, pick_code());
      else
        send_item(OP_TICK, CODE_W'($urandom));
      n++;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_TICK;
    code_i      = '0;
    out_ready_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value readback, the largest setting, then five repeats
    apb_access(1'b0, {REG_REPEAT, 2'b00}, '0);
    set_repeats(4'd15);
    set_repeats(4'd5);

    // directed: idle ticks, an out-of-range load that must wrap, loads
    // refused while busy, then the start of the first telegram
    send_item(OP_TICK, CODE_MAX);
    send_item(OP_TICK, '0);
    send_item(OP_LOAD, CODE_MAX);
    send_item(OP_LOAD, CODE_W'(CODE_SPAN - 1));
    send_item(OP_LOAD, '0);
    send_item(OP_LOAD, CODE_W'(CODE_SPAN));
    repeat (18) send_item(OP_TICK, CODE_W'($urandom));

    // phase 1: no idling; finish all 5 repeats
    run_phase(60, 1'b1, 0);
    hold_off();

    // phase 2: sender idles 72 %, repeat count zero acts as one
    send_idle_pct = 72;
    stall_pct     = 0;
    set_repeats(4'd0);
    run_phase(300, 1'b0, 0);
    hold_off();

    // phase 3: receiver stalls 72 %, two repeats; full drain halfway through
    send_idle_pct = 0;
    stall_pct     = 72;
    set_repeats(4'd2);
    run_phase(300, 1'b0, 150);
    hold_off();

    // phase 4: both sides idle 26 %, single telegram per load
    send_idle_pct = 26;
    stall_pct     = 26;
    set_repeats(4'd1);
    run_phase(300, 1'b1, 0);

    hold_off();
    repeat (20) @(negedge clk_i);

    $display("Sent %0d items under repeat counts 5, 0, 2 and 1 with four idle/stall mixes.",
             items_sent);
    $display("Checked %0d results: %0d loads taken, %0d refused while busy, %0d runs completed.",
             checked, loads, refused, finished);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
